FILE: src/rrni_pkg.sv
// Shared constants and types for the rotated raster nearest index core.
// Used by rotated_raster_nearest_index_core; depends on nothing else.
`default_nettype none

package rrni_pkg;

  // Port field widths
  localparam int COORD_W     = 12;            // target and source coordinates
  localparam int TDATA_W     = 2 * COORD_W;   // two coordinates, already whole bytes
  localparam int CFG_DATA_W  = 32;            // widest register
  localparam int CFG_INDEX_W = 3;
  localparam int EXTENT_W    = 13;

  // Arithmetic widths
  localparam int AXIS_W  = 33;   // ax, ay: Q16.16 offset plus a 12-bit pixel step
  localparam int WORD_W  = 64;   // X, Y: Q32.32, wrapping at 64 bits
  localparam int INDEX_W = 49;   // floor(|X| * scale / 2^48) before saturation

  localparam int MAX_DIM_DEFAULT = 4096;

  // Pipeline depth: ax/ay, slope products, X/Y, magnitude, scale products,
  // index sum, output word
  localparam int NSTAGE = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_SLOPE_B       = 3'd2,
    REG_SLOPE_C       = 3'd3,
    REG_SCALE_B       = 3'd4,
    REG_SCALE_C       = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_SOURCE_HEIGHT = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: src/rotated_raster_nearest_index_core.sv
// Nearest-neighbor source address generator for a rotated, clipped raster.
// Depends on rrni_pkg for widths, register codes and the pipeline depth.
//
// Usage:
//   Slave stream s_*: one target pixel per word, tdata = {target_row, target_col}.
//   Master stream m_*: one source address per word, tdata = {source_row,
//   source_col}, tuser = hit. Each input word gives exactly one output word,
//   in order.
//   Configuration: cfg_write/cfg_index/cfg_data write one register per cycle,
//   no read-back; write only while no word is in flight.
//   Pipeline: seven register stages from input accept to output valid:
//   ax/ay, slope products, X/Y, magnitude and side test, scale
//   products, index sum, output word.
//   Throughput: one word per clock; the per-stage valid chain lets the
//   pipeline keep filling while the output word waits, and s_tready drops
//   only when all seven stages hold a word and m_tready is low.
//   Reset (rst, synchronous): empties the pipeline and loads the register
//   defaults (offsets and slopes 0, scales 1.0, extents 4096).
//   A stall on m_tready holds only the blocked stages; nothing is dropped or repeated.
`default_nettype none

module rotated_raster_nearest_index_core #(
  parameter int MAX_DIM = rrni_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_write,
  input  wire logic [rrni_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rrni_pkg::CFG_DATA_W-1:0]  cfg_data,
  // target pixels
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [rrni_pkg::TDATA_W-1:0]     s_tdata,   // [11:0] target_col, [23:12] target_row
  // source addresses
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [rrni_pkg::TDATA_W-1:0]          m_tdata,   // [11:0] source_col, [23:12] source_row
  output logic                                  m_tuser    // [0] hit
);
  import rrni_pkg::*;

  localparam logic [INDEX_W-1:0] DIM_LIMIT = INDEX_W'(MAX_DIM);
  localparam logic [INDEX_W-1:0] DIM_SAT   = INDEX_W'(MAX_DIM - 1);

  // ---------------------------------------------------------------- registers
  logic signed [31:0]   offset_x, offset_y, slope_b, slope_c;
  logic [31:0]          scale_b, scale_c;
  logic [EXTENT_W-1:0]  source_width, source_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      slope_b       <= '0;
      slope_c       <= '0;
      scale_b       <= 32'h0001_0000;
      scale_c       <= 32'h0001_0000;
      source_width  <= EXTENT_W'(4096);
      source_height <= EXTENT_W'(4096);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:      offset_x      <= cfg_data;
        REG_OFFSET_Y:      offset_y      <= cfg_data;
        REG_SLOPE_B:       slope_b       <= cfg_data;
        REG_SLOPE_C:       slope_c       <= cfg_data;
        REG_SCALE_B:       scale_b       <= cfg_data;
        REG_SCALE_C:       scale_c       <= cfg_data;
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[EXTENT_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[EXTENT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- valid chain
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NSTAGE-1];

  // -------------------------------------------------- stage 0: ax and ay
  logic signed [AXIS_W-1:0] p0_ax, p0_ay;
  logic signed [AXIS_W-1:0] ax_next, ay_next;
  logic signed [AXIS_W-1:0] col_step, row_step;

  always_comb begin
    col_step = $signed({5'b0, s_tdata[COORD_W-1:0], 16'h0});
    row_step = $signed({5'b0, s_tdata[TDATA_W-1:COORD_W], 16'h0});
    ax_next  = AXIS_W'(offset_x) + col_step;
    ay_next  = AXIS_W'(offset_y) - row_step;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) begin
      p0_ax <= ax_next;
      p0_ay <= ay_next;
    end
  end

  // ------------------------------------- stage 1: slope times ay, in halves
  logic signed [16:0] ay_lo, ay_hi;
  logic signed [48:0] p1_bl, p1_bh, p1_cl, p1_ch;
  logic signed [AXIS_W-1:0] p1_ax, p1_ay;

  assign ay_lo = $signed({1'b0, p0_ay[15:0]});
  assign ay_hi = p0_ay[AXIS_W-1:16];

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      p1_bl <= slope_b * ay_lo;
      p1_bh <= slope_b * ay_hi;
      p1_cl <= slope_c * ay_lo;
      p1_ch <= slope_c * ay_hi;
      p1_ax <= p0_ax;
      p1_ay <= p0_ay;
    end
  end

  // ---------------------------------------- stage 2: X and Y by mode, Q32.32
  logic signed [WORD_W-1:0] ax_w, ay_w, ax_sh, ay_sh, prod_b, prod_c;
  logic signed [WORD_W-1:0] bh_w, ch_w;
  logic signed [WORD_W-1:0] x_next, y_next;
  logic signed [WORD_W-1:0] p2_x, p2_y;
  logic                     east_up, left_level;

  assign east_up    = (slope_b == '0);
  assign left_level = (slope_c == '0);

  always_comb begin
    ax_w   = WORD_W'(p1_ax);
    ay_w   = WORD_W'(p1_ay);
    bh_w   = WORD_W'(p1_bh);
    ch_w   = WORD_W'(p1_ch);
    ax_sh  = {ax_w[WORD_W-17:0], 16'h0};
    ay_sh  = {ay_w[WORD_W-17:0], 16'h0};
    prod_b = WORD_W'(p1_bl) + {bh_w[WORD_W-17:0], 16'h0};
    prod_c = WORD_W'(p1_cl) + {ch_w[WORD_W-17:0], 16'h0};
    if (east_up) begin
      x_next = ay_sh;
      y_next = ax_sh;
    end else if (left_level) begin
      x_next = ax_sh;
      y_next = ay_sh;
    end else begin
      x_next = ax_sh - prod_c;
      y_next = ax_sh - prod_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      p2_x <= x_next;
      p2_y <= y_next;
    end
  end

  // ------------------------------ stage 3: wrong-side test and magnitudes
  logic signed [AXIS_W-1:0] slope_diff;
  logic                     sd_pos, sd_neg, x_pos, y_pos, miss_next;
  logic [WORD_W-1:0]        p3_mx, p3_my;
  logic                     p3_miss;

  always_comb begin
    slope_diff = AXIS_W'(slope_b) - AXIS_W'(slope_c);
    sd_neg     = slope_diff[AXIS_W-1];
    sd_pos     = !sd_neg && (slope_diff != '0);
    x_pos      = !p2_x[WORD_W-1] && (p2_x != '0);
    y_pos      = !p2_y[WORD_W-1] && (p2_y != '0);
    miss_next  = !east_up && !left_level &&
                 ((sd_pos && (x_pos || y_pos)) ||
                  (sd_neg && (p2_x[WORD_W-1] || p2_y[WORD_W-1])));
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      p3_mx   <= p2_x[WORD_W-1] ? WORD_W'(-p2_x) : WORD_W'(p2_x);
      p3_my   <= p2_y[WORD_W-1] ? WORD_W'(-p2_y) : WORD_W'(p2_y);
      p3_miss <= miss_next;
    end
  end

  // ------------------------------- stage 4: magnitude times scale, halves
  logic [63:0] p4_xh, p4_xl, p4_yh, p4_yl;
  logic        p4_miss;

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      p4_xh   <= p3_mx[63:32] * scale_b;
      p4_xl   <= p3_mx[31:0]  * scale_b;
      p4_yh   <= p3_my[63:32] * scale_c;
      p4_yl   <= p3_my[31:0]  * scale_c;
      p4_miss <= p3_miss;
    end
  end

  // ------------------------------------ stage 5: index = product >> 48
  logic [64:0]        sum_x, sum_y;
  logic [INDEX_W-1:0] p5_ix, p5_iy;
  logic               p5_miss;

  assign sum_x = {1'b0, p4_xh} + {33'b0, p4_xl[63:32]};
  assign sum_y = {1'b0, p4_yh} + {33'b0, p4_yl[63:32]};

  always_ff @(posedge clk) begin
    if (rdy[5] && vld[4]) begin
      p5_ix   <= sum_x[64:16];
      p5_iy   <= sum_y[64:16];
      p5_miss <= p4_miss;
    end
  end

  // -------------------------- stage 6: saturate, extent check, output word
  logic               sat_x, sat_y, hit_next;
  logic [INDEX_W-1:0] ix_sat, iy_sat;

  always_comb begin
    sat_x    = (p5_ix >= DIM_LIMIT);
    sat_y    = (p5_iy >= DIM_LIMIT);
    ix_sat   = sat_x ? DIM_SAT : p5_ix;
    iy_sat   = sat_y ? DIM_SAT : p5_iy;
    hit_next = !p5_miss && !sat_x && !sat_y &&
               (ix_sat < INDEX_W'(source_width)) &&
               (iy_sat < INDEX_W'(source_height));
  end

  always_ff @(posedge clk) begin
    if (rdy[6] && vld[5]) begin
      m_tdata <= p5_miss ? '0 : {iy_sat[COORD_W-1:0], ix_sat[COORD_W-1:0]};
      m_tuser <= hit_next;
    end
  end

  // --------------------------------------------------------------- checks
  // Pipeline empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // Input backpressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("s_tready low with a free stage");

  // Occupancy follows accepted input and output words.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) == $countones($past(vld))
                     + int'($past(s_tvalid && s_tready))
                     - int'($past(m_tvalid && m_tready))))
    else $error("word lost or duplicated in pipeline");

  // A hit needs a nonzero source extent.
  a_hit_extent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ((source_width != '0) && (source_height != '0)))
    else $error("hit reported with empty source extent");

endmodule

`default_nettype wire
